/* rtl/cld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lens distortion point package
// Shared fixed-point types, register indexes, reset values and the Q4.28
// rounding and saturation helpers used throughout the distortion pipeline.
// ----------------------------------------------------------------------------
package cld_pkg;

    // Internal normalised format: signed Q4.28.
    typedef logic signed [31:0] q28_t;

    // Pixel coordinates: signed Q12.4.
    typedef logic signed [15:0] pix_t;

    // Configuration register indexes.
    localparam int          CFG_IDX_W         = 3;
    localparam logic [2:0]  REG_OUT_FOCAL     = 3'd0;
    localparam logic [2:0]  REG_IN_INV_FOCAL  = 3'd1;
    localparam logic [2:0]  REG_CENTER_QUAD   = 3'd2;
    localparam logic [2:0]  REG_RADIAL_K1     = 3'd3;
    localparam logic [2:0]  REG_RADIAL_K2     = 3'd4;
    localparam logic [2:0]  REG_RADIAL_K3     = 3'd5;
    localparam logic [2:0]  REG_TANGENTIAL_P1 = 3'd6;
    localparam logic [2:0]  REG_TANGENTIAL_P2 = 3'd7;

    // Reset values: unit focal lengths and unit reciprocals, zero centres.
    localparam logic [63:0] OUT_FOCAL_RST     = 64'h0001_0000_0001_0000;
    localparam logic [63:0] IN_INV_FOCAL_RST  = 64'h0100_0000_0100_0000;

    localparam q28_t Q28_ONE = 32'sh1000_0000;
    localparam q28_t Q28_MAX = 32'sh7fff_ffff;
    localparam q28_t Q28_MIN = 32'sh8000_0000;

    localparam pix_t PIX_MAX = 16'sh7fff;
    localparam pix_t PIX_MIN = 16'sh8000;

    // Pipeline depths of the three units.
    localparam int NORM_STAGES = 3;
    localparam int POLY_STAGES = 13;
    localparam int PROJ_STAGES = 3;

    // Saturate a 64-bit signed value into Q4.28.
    function automatic q28_t sat28(input logic signed [63:0] v);
        q28_t r;
        if (v[63:31] == {33{v[63]}}) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = Q28_MIN;
        end else begin
            r = Q28_MAX;
        end
        return r;
    endfunction

    // Round a Q8.56 product to 28 fraction bits (half up) and saturate.
    function automatic q28_t rnd28(input logic signed [63:0] p);
        logic signed [64:0] t;
        t = {p[63], p} + 65'sd134217728;
        return sat28({{27{t[64]}}, t[64:28]});
    endfunction

endpackage

/* rtl/cld_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point normalisation
// Subtracts the source centre and scales by the reciprocal source focal
// length, giving saturated Q4.28 coordinates after three register stages.
// ----------------------------------------------------------------------------
module cld_norm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cld_pkg::pix_t        pixel_x,
    input  cld_pkg::pix_t        pixel_y,
    input  logic [15:0]          src_cx,
    input  logic [15:0]          src_cy,
    input  logic [31:0]          inv_fx,
    input  logic [31:0]          inv_fy,
    output logic                 out_valid,
    output cld_pkg::q28_t        norm_x,
    output cld_pkg::q28_t        norm_y
);
    import cld_pkg::*;

    logic [NORM_STAGES-1:0] vld_reg;
    logic signed [17:0]     dx_reg, dy_reg;
    logic signed [50:0]     px_reg, py_reg;
    logic signed [50:0]     px_next, py_next;
    q28_t                   nx_reg, ny_reg;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NORM_STAGES-2:0], in_valid};
        end
    end

    // Products of the centred coordinates and the reciprocals.
    assign px_next = dx_reg * $signed({1'b0, inv_fx});
    assign py_next = dy_reg * $signed({1'b0, inv_fy});

    // Subtract, multiply, saturate.
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= 18'(pixel_x) - $signed({2'b00, src_cx});
            dy_reg <= 18'(pixel_y) - $signed({2'b00, src_cy});
            px_reg <= px_next;
            py_reg <= py_next;
            nx_reg <= sat28(64'(px_reg));
            ny_reg <= sat28(64'(py_reg));
        end
    end

    assign out_valid = vld_reg[NORM_STAGES-1];
    assign norm_x    = nx_reg;
    assign norm_y    = ny_reg;

    // A source centre is never negative, so a centred coordinate does not exceed
    // the positive pixel limit.
    a_dx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> (dx_reg <= 18'sd32767 && dy_reg <= 18'sd32767))
        else $error("centred coordinate exceeds the pixel range");

endmodule

/* rtl/cld_poly.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial and tangential distortion core
// Evaluates the Brown-Conrady terms on a normalised point. Each multiply
// stage is followed by a rounding stage; sums have stages of their own.
// ----------------------------------------------------------------------------
module cld_poly (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cld_pkg::q28_t        norm_x,
    input  cld_pkg::q28_t        norm_y,
    input  cld_pkg::q28_t        k1,
    input  cld_pkg::q28_t        k2,
    input  cld_pkg::q28_t        k3,
    input  cld_pkg::q28_t        p1,
    input  cld_pkg::q28_t        p2,
    output logic                 out_valid,
    output cld_pkg::q28_t        dist_x,
    output cld_pkg::q28_t        dist_y
);
    import cld_pkg::*;

    logic [POLY_STAGES-1:0] vld_reg;

    // Delay lines for values needed again further down.
    q28_t x_d_reg  [1:10];
    q28_t y_d_reg  [1:10];
    q28_t xy_d_reg [2:10];
    q28_t tx_d_reg [4:10];
    q28_t ty_d_reg [4:10];
    q28_t r2_d_reg [3:5];
    q28_t k1r2_d_reg [5:9];
    q28_t k2r4_d_reg [7:9];

    logic signed [63:0] pxx_reg, pyy_reg, pxy_reg;
    q28_t               xx_reg, yy_reg, xx3_reg, yy3_reg;
    logic signed [63:0] pr4_reg, pk1_reg, pr6_reg, pk2_reg, pk3_reg;
    q28_t               r4_reg, r6_reg, k3r6_reg, f_reg;
    logic signed [63:0] pxf_reg, pyf_reg, pp1xy_reg, pp2tx_reg, pp1ty_reg, pp2xy_reg;
    q28_t               xf_reg, yf_reg, p1xy_reg, p2tx_reg, p1ty_reg, p2xy_reg;
    q28_t               xd_reg, yd_reg;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[POLY_STAGES-2:0], in_valid};
        end
    end

    // Delay lines.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_d_reg[1] <= norm_x;
            y_d_reg[1] <= norm_y;
            for (int i = 2; i <= 10; i++) begin
                x_d_reg[i] <= x_d_reg[i-1];
                y_d_reg[i] <= y_d_reg[i-1];
            end
            xy_d_reg[2] <= rnd28(pxy_reg);
            for (int i = 3; i <= 10; i++) begin
                xy_d_reg[i] <= xy_d_reg[i-1];
            end
            tx_d_reg[4] <= sat28(64'(r2_d_reg[3]) + (64'(xx3_reg) <<< 1));
            ty_d_reg[4] <= sat28(64'(r2_d_reg[3]) + (64'(yy3_reg) <<< 1));
            for (int i = 5; i <= 10; i++) begin
                tx_d_reg[i] <= tx_d_reg[i-1];
                ty_d_reg[i] <= ty_d_reg[i-1];
            end
            r2_d_reg[3] <= sat28(64'(xx_reg) + 64'(yy_reg));
            r2_d_reg[4] <= r2_d_reg[3];
            r2_d_reg[5] <= r2_d_reg[4];
            k1r2_d_reg[5] <= rnd28(pk1_reg);
            for (int i = 6; i <= 9; i++) begin
                k1r2_d_reg[i] <= k1r2_d_reg[i-1];
            end
            k2r4_d_reg[7] <= rnd28(pk2_reg);
            k2r4_d_reg[8] <= k2r4_d_reg[7];
            k2r4_d_reg[9] <= k2r4_d_reg[8];
        end
    end

    // Squares, r squared and its powers, and the radial factor.
    always_ff @(posedge aclk) begin
        if (en) begin
            pxx_reg  <= norm_x * norm_x;
            pyy_reg  <= norm_y * norm_y;
            pxy_reg  <= norm_x * norm_y;
            xx_reg   <= rnd28(pxx_reg);
            yy_reg   <= rnd28(pyy_reg);
            xx3_reg  <= xx_reg;
            yy3_reg  <= yy_reg;
            pr4_reg  <= r2_d_reg[3] * r2_d_reg[3];
            pk1_reg  <= k1 * r2_d_reg[3];
            r4_reg   <= rnd28(pr4_reg);
            pr6_reg  <= r4_reg * r2_d_reg[5];
            pk2_reg  <= k2 * r4_reg;
            r6_reg   <= rnd28(pr6_reg);
            pk3_reg  <= k3 * r6_reg;
            k3r6_reg <= rnd28(pk3_reg);
            f_reg    <= sat28(64'(Q28_ONE) + 64'(k1r2_d_reg[9]) + 64'(k2r4_d_reg[9])
                              + 64'(k3r6_reg));
        end
    end

    // Radial scaling, tangential terms and final sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            pxf_reg   <= x_d_reg[10] * f_reg;
            pyf_reg   <= y_d_reg[10] * f_reg;
            pp1xy_reg <= p1 * xy_d_reg[10];
            pp2tx_reg <= p2 * tx_d_reg[10];
            pp1ty_reg <= p1 * ty_d_reg[10];
            pp2xy_reg <= p2 * xy_d_reg[10];
            xf_reg    <= rnd28(pxf_reg);
            yf_reg    <= rnd28(pyf_reg);
            p1xy_reg  <= rnd28(pp1xy_reg);
            p2tx_reg  <= rnd28(pp2tx_reg);
            p1ty_reg  <= rnd28(pp1ty_reg);
            p2xy_reg  <= rnd28(pp2xy_reg);
            xd_reg    <= sat28(64'(xf_reg) + (64'(p1xy_reg) <<< 1) + 64'(p2tx_reg));
            yd_reg    <= sat28(64'(yf_reg) + 64'(p1ty_reg) + (64'(p2xy_reg) <<< 1));
        end
    end

    assign out_valid = vld_reg[POLY_STAGES-1];
    assign dist_x    = xd_reg;
    assign dist_y    = yd_reg;

    // A stall freezes every valid bit of the core.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("distortion core moved while stalled");

endmodule

/* rtl/cld_proj.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target projection
// Scales the distorted point by the target focal length, rounds to Q12.4,
// adds the target centre and clamps to the pixel range.
// ----------------------------------------------------------------------------
module cld_proj (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cld_pkg::q28_t        dist_x,
    input  cld_pkg::q28_t        dist_y,
    input  logic [31:0]          fx,
    input  logic [31:0]          fy,
    input  logic [15:0]          dst_cx,
    input  logic [15:0]          dst_cy,
    output logic                 out_valid,
    output cld_pkg::pix_t        warped_x,
    output cld_pkg::pix_t        warped_y,
    output logic                 clipped
);
    import cld_pkg::*;

    logic [PROJ_STAGES-1:0] vld_reg;
    logic signed [64:0]     pdx_reg, pdy_reg;
    logic signed [65:0]     tx_rnd, ty_rnd;
    logic signed [26:0]     sx_reg, sy_reg, sx_next, sy_next;
    pix_t                   wx_reg, wy_reg;
    logic                   clip_reg;
    pix_t                   wx_next, wy_next;
    logic                   clip_x, clip_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PROJ_STAGES-2:0], in_valid};
        end
    end

    // Round from 44 to 4 fraction bits and add the centre.
    always_comb begin
        tx_rnd  = 66'(pdx_reg) + (66'sd1 <<< 39);
        ty_rnd  = 66'(pdy_reg) + (66'sd1 <<< 39);
        sx_next = 27'($signed(tx_rnd[65:40])) + $signed({11'b0, dst_cx});
        sy_next = 27'($signed(ty_rnd[65:40])) + $signed({11'b0, dst_cy});
    end

    // Clamp to the signed pixel range.
    always_comb begin
        clip_x  = 1'b1;
        clip_y  = 1'b1;
        if (sx_reg > 27'(PIX_MAX)) begin
            wx_next = PIX_MAX;
        end else if (sx_reg < 27'(PIX_MIN)) begin
            wx_next = PIX_MIN;
        end else begin
            wx_next = sx_reg[15:0];
            clip_x  = 1'b0;
        end
        if (sy_reg > 27'(PIX_MAX)) begin
            wy_next = PIX_MAX;
        end else if (sy_reg < 27'(PIX_MIN)) begin
            wy_next = PIX_MIN;
        end else begin
            wy_next = sy_reg[15:0];
            clip_y  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pdx_reg  <= dist_x * $signed({1'b0, fx});
            pdy_reg  <= dist_y * $signed({1'b0, fy});
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            clip_reg <= clip_x | clip_y;
        end
    end

    assign out_valid = vld_reg[PROJ_STAGES-1];
    assign warped_x  = wx_reg;
    assign warped_y  = wy_reg;
    assign clipped   = clip_reg;

endmodule

/* rtl/camera_lens_distortion_point.sv */
`timescale 1ns / 1ps
// The path holds 20 register stages, including the output register.
// Throughput: one point per clock while the output is not stalled; every stage
// is a register. The output register's ready drives a common stage enable, so
// a stall freezes the whole pipeline in place.
// Reset clears all valid bits and restores the configuration registers.
// ----------------------------------------------------------------------------
// Lens distortion of one pixel point
// Normalises a point with the source camera, applies radial and tangential
// distortion in Q4.28, and projects it with the target camera.
// ----------------------------------------------------------------------------
module camera_lens_distortion_point (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [cld_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [63:0]                   cfg_wr_data,
    // Input point stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // pixel_x[15:0], pixel_y[31:16]
    // Output point stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // warped_x[15:0], warped_y[31:16]
    output logic [0:0]                    m_tuser   // clipped[0]
);
    import cld_pkg::*;

    logic [63:0] out_focal_reg, in_inv_focal_reg, center_quad_reg;
    q28_t        k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;

    logic        en;
    logic        norm_valid, poly_valid, proj_valid;
    q28_t        norm_x, norm_y, dist_x, dist_y;
    pix_t        proj_x, proj_y;
    logic        proj_clip;

    logic        m_tvalid_reg;
    pix_t        wx_reg, wy_reg;
    logic        clip_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_focal_reg    <= OUT_FOCAL_RST;
            in_inv_focal_reg <= IN_INV_FOCAL_RST;
            center_quad_reg  <= '0;
            k1_reg           <= '0;
            k2_reg           <= '0;
            k3_reg           <= '0;
            p1_reg           <= '0;
            p2_reg           <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_OUT_FOCAL:     out_focal_reg    <= cfg_wr_data;
                REG_IN_INV_FOCAL:  in_inv_focal_reg <= cfg_wr_data;
                REG_CENTER_QUAD:   center_quad_reg  <= cfg_wr_data;
                REG_RADIAL_K1:     k1_reg           <= cfg_wr_data[31:0];
                REG_RADIAL_K2:     k2_reg           <= cfg_wr_data[31:0];
                REG_RADIAL_K3:     k3_reg           <= cfg_wr_data[31:0];
                REG_TANGENTIAL_P1: p1_reg           <= cfg_wr_data[31:0];
                REG_TANGENTIAL_P2: p2_reg           <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a result.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cld_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel_x   (s_tdata[15:0]),
        .pixel_y   (s_tdata[31:16]),
        .src_cx    (center_quad_reg[47:32]),
        .src_cy    (center_quad_reg[63:48]),
        .inv_fx    (in_inv_focal_reg[31:0]),
        .inv_fy    (in_inv_focal_reg[63:32]),
        .out_valid (norm_valid),
        .norm_x    (norm_x),
        .norm_y    (norm_y)
    );

    cld_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (norm_valid),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .k1        (k1_reg),
        .k2        (k2_reg),
        .k3        (k3_reg),
        .p1        (p1_reg),
        .p2        (p2_reg),
        .out_valid (poly_valid),
        .dist_x    (dist_x),
        .dist_y    (dist_y)
    );

    cld_proj u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (poly_valid),
        .dist_x    (dist_x),
        .dist_y    (dist_y),
        .fx        (out_focal_reg[31:0]),
        .fy        (out_focal_reg[63:32]),
        .dst_cx    (center_quad_reg[15:0]),
        .dst_cy    (center_quad_reg[31:16]),
        .out_valid (proj_valid),
        .warped_x  (proj_x),
        .warped_y  (proj_y),
        .clipped   (proj_clip)
    );

    // Output register holding one transaction until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= proj_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg   <= proj_x;
            wy_reg   <= proj_y;
            clip_reg <= proj_clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {wy_reg, wx_reg};
    assign m_tuser  = clip_reg;

    // A clipped result has at least one coordinate on a rail.
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (wx_reg == PIX_MAX || wx_reg == PIX_MIN ||
             wy_reg == PIX_MAX || wy_reg == PIX_MIN))
        else $error("clipped flag without a saturated coordinate");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
